// ===== rtl/core/rcn_pkg.sv =====
// Package for the RC network Euler step block and its Q4.28 multiply rcn_mulq.
// Holds shared constants, mode codes, state type and a 36-to-32-bit saturator.
package rcn_pkg;

   localparam int NODE_COUNT_DEF = 8;
   localparam int COMP_COUNT_DEF = 8;
   localparam int MAX_RESULTS    = 8;
   localparam int CSR_IDX_W      = 1;
   localparam int CSR_DATA_W     = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_COMPONENTS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_NODES      = 1'd1;

   localparam logic [1:0] MODE_LOAD = 2'd0;
   localparam logic [1:0] MODE_HOLD = 2'd1;
   localparam logic [1:0] MODE_GAIN = 2'd2;
   localparam logic [1:0] MODE_TICK = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FORCE,
      ST_COMP_RD,
      ST_COMP_MUL,
      ST_COMP_CAP,
      ST_COMP_WR,
      ST_NODE_RD,
      ST_NODE_MUL,
      ST_NODE_OUT
   } state_type;

   function automatic logic signed [31:0] sat32(input logic signed [35:0] x);
      logic signed [31:0] r;
      if (x > 36'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
      else if (x < -36'sh0_8000_0000) r = 32'sh8000_0000;
      else r = x[31:0];
      return r;
   endfunction

endpackage

// ===== rtl/core/rcn_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module rcn_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ===== rtl/core/rcn_mulq.sv =====
// Signed Q16.16 by unsigned Q4.28 multiply, rounded half away, saturated.
// Two registered stages; depends on rcn_pkg.
module rcn_mulq import rcn_pkg::*; (
   input  logic               clock,
   input  logic signed [31:0] x,
   input  logic [31:0]        g,
   output logic signed [31:0] y
);
   logic        neg_ff;
   logic [63:0] prod_ff;
   logic [32:0] mag;
   logic [36:0] r;
   logic signed [37:0] s;
   logic signed [31:0] y_ff, y_in;

   always_comb begin
      mag = x[31] ? (33'd0 - {x[31], x}) : {1'b0, x};
   end

   always_ff @(posedge clock) begin
      neg_ff  <= x[31];
      prod_ff <= mag[31:0] * g + (mag[32] ? {g, 32'd0} : 64'd0);
      y_ff    <= y_in;
   end

   always_comb begin
      r = 37'((prod_ff + 64'h800_0000) >> 28);
      s = neg_ff ? -$signed({1'b0, r}) : $signed({1'b0, r});
      if (s > 38'sh7FFF_FFFF) y_in = 32'sh7FFF_FFFF;
      else if (s < -38'sh8000_0000) y_in = 32'sh8000_0000;
      else y_in = s[31:0];
   end

   assign y = y_ff;
endmodule

// ===== rtl/core/rc_network_euler_step.sv =====
// RC network explicit-Euler step. Load, hold and gain words are taken while idle
// and can follow back to back. A tick stalls the input until its last result
// has been taken: it forces held nodes over all NODE_COUNT nodes, then walks
// each active component through a shared two-stage multiplier (RAM reads,
// current, capacitor step, writeback), then each reported node, which can be
// held by an output stall. Component, voltage, gain and hold stores live in
// synchronous RAMs with registered read data; uses rcn_pkg, rcn_ram and rcn_mulq.
module rc_network_euler_step import rcn_pkg::*; #(
   parameter int NODE_COUNT = NODE_COUNT_DEF,
   parameter int COMP_COUNT = COMP_COUNT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_mode,
   input  logic [2:0]            req_index,
   input  logic [2:0]            req_node_a,
   input  logic [2:0]            req_node_b,
   input  logic [31:0]           req_conductance,
   input  logic [31:0]           req_cap_factor,
   input  logic                  req_hold_enable,
   input  logic signed [31:0]    req_hold_voltage,
   input  logic [31:0]           req_node_gain,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [2:0]            rsp_node,
   output logic signed [31:0]    rsp_voltage,
   output logic signed [31:0]    rsp_current,
   output logic                  rsp_last,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);
   localparam int NW = $clog2(NODE_COUNT);
   localparam int CW = (COMP_COUNT > 1) ? $clog2(COMP_COUNT) : 1;
   localparam int NCW = $clog2(NODE_COUNT + 1);
   localparam int CCW = $clog2(COMP_COUNT + 1);

   state_type state_ff, state_in;
   logic [3:0] act_comp_ff, act_node_ff;
   logic [NCW-1:0] ncnt_ff, ncnt_in, nlim;
   logic [CCW-1:0] ccnt_ff, ccnt_in, clim;
   logic [1:0] sub_ff, sub_in;
   logic [NODE_COUNT-1:0] hvalid_ff, gvalid_ff, vvalid_ff;
   logic [COMP_COUNT-1:0] cvalid_ff;
   logic signed [35:0] inet_ff [NODE_COUNT];

   // RAM ports
   logic nv_we; logic [NW-1:0] nv_wa, nv_ra; logic [31:0] nv_wd, nv_rd;
   logic cv_we; logic [CW-1:0] cv_wa, cv_ra; logic [31:0] cv_wd, cv_rd;
   logic cp_we; logic [CW-1:0] cp_wa, cp_ra; logic [69:0] cp_wd, cp_rd;
   logic ng_we; logic [NW-1:0] ng_wa, ng_ra; logic [31:0] ng_wd, ng_rd;
   logic nh_we; logic [NW-1:0] nh_wa, nh_ra; logic [32:0] nh_wd, nh_rd;

   // latched per-component operands
   logic [2:0] ta_ff, tb_ff;
   logic [31:0] va_ff, g_ff, cf_ff, vcap_ff;
   logic signed [31:0] cur_ff, mul_x, mul_y;
   logic [31:0] mul_g;
   logic signed [31:0] vnode_ff, ires_ff;
   logic rv_ff, rv_in; logic [2:0] rn_ff; logic signed [31:0] rvolt_ff, rcur_ff; logic rl_ff;

   logic accept;
   logic [31:0] vnr, cvr, ngr; logic [32:0] nhr;

   rcn_ram #(.WIDTH(32), .DEPTH(NODE_COUNT)) u_nv (.clock, .wr_en(nv_we), .wr_addr(nv_wa),
      .wr_data(nv_wd), .rd_addr(nv_ra), .rd_data(nv_rd));
   rcn_ram #(.WIDTH(32), .DEPTH(COMP_COUNT)) u_cv (.clock, .wr_en(cv_we), .wr_addr(cv_wa),
      .wr_data(cv_wd), .rd_addr(cv_ra), .rd_data(cv_rd));
   rcn_ram #(.WIDTH(70), .DEPTH(COMP_COUNT)) u_cp (.clock, .wr_en(cp_we), .wr_addr(cp_wa),
      .wr_data(cp_wd), .rd_addr(cp_ra), .rd_data(cp_rd));
   rcn_ram #(.WIDTH(32), .DEPTH(NODE_COUNT)) u_ng (.clock, .wr_en(ng_we), .wr_addr(ng_wa),
      .wr_data(ng_wd), .rd_addr(ng_ra), .rd_data(ng_rd));
   rcn_ram #(.WIDTH(33), .DEPTH(NODE_COUNT)) u_nh (.clock, .wr_en(nh_we), .wr_addr(nh_wa),
      .wr_data(nh_wd), .rd_addr(nh_ra), .rd_data(nh_rd));

   rcn_mulq u_mul (.clock, .x(mul_x), .g(mul_g), .y(mul_y));

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE) || rv_ff;
   assign rsp_valid = rv_ff;
   assign rsp_node = rn_ff;
   assign rsp_voltage = rvolt_ff;
   assign rsp_current = rcur_ff;
   assign rsp_last = rl_ff;

   // raise on a new result, hold while stalled, drop once taken
   assign rv_in = (state_ff == ST_NODE_OUT && (!rv_ff || !rsp_stall)) || (rv_ff && rsp_stall);

   always_comb begin
      clim = (int'(act_comp_ff) > COMP_COUNT) ? CCW'(COMP_COUNT) : CCW'(act_comp_ff);
      if (int'(act_node_ff) > NODE_COUNT) nlim = NCW'(NODE_COUNT);
      else nlim = NCW'(act_node_ff);
      if (int'(nlim) > MAX_RESULTS) nlim = NCW'(MAX_RESULTS);
   end

   // reset-cleared stores read as zero until written; their read indexes are
   // registered so the index of the read is the one issued last cycle
   logic [NW-1:0] nv_ra_ff, ng_ra_ff, nh_ra_ff; logic [CW-1:0] cv_ra_ff;
   always_ff @(posedge clock) begin
      nv_ra_ff <= nv_ra; ng_ra_ff <= ng_ra; nh_ra_ff <= nh_ra; cv_ra_ff <= cv_ra;
   end
   assign vnr = vvalid_ff[nv_ra_ff] ? nv_rd : 32'd0;
   assign ngr = gvalid_ff[ng_ra_ff] ? ng_rd : 32'd0;
   assign nhr = hvalid_ff[nh_ra_ff] ? nh_rd : 33'd0;
   assign cvr = cvalid_ff[cv_ra_ff] ? cv_rd : 32'd0;

   logic signed [35:0] vd_full;
   logic signed [31:0] half;
   logic signed [31:0] vb_val, va_val;
   logic signed [35:0] inet_sel;

   always_comb begin
      state_in = state_ff; ncnt_in = ncnt_ff; ccnt_in = ccnt_ff; sub_in = sub_ff;
      nv_we = 1'b0; nv_wa = NW'(req_index); nv_wd = nhr[31:0];
      nv_ra = ncnt_ff[NW-1:0];
      cv_we = 1'b0; cv_wa = CW'(req_index); cv_wd = 32'd0; cv_ra = ccnt_ff[CW-1:0];
      cp_we = 1'b0; cp_wa = CW'(req_index);
      cp_wd = {req_node_b, req_node_a, req_conductance, req_cap_factor};
      cp_ra = ccnt_ff[CW-1:0];
      ng_we = 1'b0; ng_wa = NW'(req_index); ng_wd = req_node_gain; ng_ra = ncnt_ff[NW-1:0];
      nh_we = 1'b0; nh_wa = NW'(req_index);
      nh_wd = {req_hold_enable, req_hold_voltage}; nh_ra = ncnt_ff[NW-1:0];
      vb_val = 32'sd0; va_val = 32'sd0; vd_full = 36'sd0; half = cur_ff / 2;
      mul_x = $signed(vd_full[31:0]); mul_g = g_ff;
      inet_sel = inet_ff[ncnt_ff[NW-1:0]];
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_mode)
                  MODE_LOAD: begin
                     if (32'(req_index) < COMP_COUNT) begin
                        cp_we = 1'b1; cv_we = 1'b1;
                     end
                  end
                  MODE_HOLD: nh_we = 32'(req_index) < NODE_COUNT;
                  MODE_GAIN: ng_we = 32'(req_index) < NODE_COUNT;
                  default: begin
                     ncnt_in = '0; sub_in = 2'd0; state_in = ST_FORCE;
                  end
               endcase
            end
         end
         ST_FORCE: begin
            // read hold store, then write voltage in the next cycle
            nh_ra = ncnt_ff[NW-1:0];
            if (sub_ff == 2'd0) sub_in = 2'd1;
            else begin
               nh_ra = ncnt_ff[NW-1:0];
               nv_wa = ncnt_ff[NW-1:0];
               nv_we = nhr[32];
               sub_in = 2'd0;
               if (ncnt_ff == NCW'(NODE_COUNT - 1)) begin
                  ccnt_in = '0;
                  if (clim != '0) state_in = ST_COMP_RD;
                  else state_in = (nlim == '0) ? ST_IDLE : ST_NODE_RD;
                  ncnt_in = '0;
               end else ncnt_in = ncnt_ff + 1'b1;
            end
         end
         ST_COMP_RD: begin
            // sub 0: read params+vcap; sub 1: read Va; sub 2: read Vb
            case (sub_ff)
               2'd0: sub_in = 2'd1;
               2'd1: begin nv_ra = NW'(cp_rd[66:64]); sub_in = 2'd2; end
               2'd2: begin nv_ra = NW'(tb_ff); sub_in = 2'd3; end
               default: begin
                  nv_ra = NW'(tb_ff);
                  vb_val = (32'(tb_ff) < NODE_COUNT) ? $signed(vnr) : 32'sd0;
                  va_val = (32'(ta_ff) < NODE_COUNT) ? $signed(va_ff) : 32'sd0;
                  vd_full = 36'(vb_val) - 36'(va_val) + 36'($signed(vcap_ff));
                  vd_full = 36'(sat32(vd_full));
                  mul_x = $signed(vd_full[31:0]); mul_g = g_ff;
                  sub_in = 2'd0; state_in = ST_COMP_MUL;
               end
            endcase
         end
         ST_COMP_MUL: begin
            mul_g = g_ff;
            if (sub_ff == 2'd1) begin sub_in = 2'd0; state_in = ST_COMP_CAP; end
            else sub_in = 2'd1;
         end
         ST_COMP_CAP: begin
            mul_x = cur_ff; mul_g = cf_ff;
            if (sub_ff == 2'd1) begin sub_in = 2'd0; state_in = ST_COMP_WR; end
            else sub_in = 2'd1;
         end
         ST_COMP_WR: begin
            mul_x = cur_ff; mul_g = cf_ff;
            cv_we = 1'b1; cv_wa = ccnt_ff[CW-1:0];
            cv_wd = sat32(36'($signed(vcap_ff)) - 36'(mul_y));
            if (ccnt_ff + 1'b1 == clim) begin
               ccnt_in = '0; ncnt_in = '0;
               state_in = (nlim == '0) ? ST_IDLE : ST_NODE_RD;
            end else begin
               ccnt_in = ccnt_ff + 1'b1; state_in = ST_COMP_RD;
            end
         end
         ST_NODE_RD: begin
            if (sub_ff == 2'd0) sub_in = 2'd1;
            else begin
               mul_x = sat32(inet_sel); mul_g = ngr;
               sub_in = 2'd0; state_in = ST_NODE_MUL;
            end
         end
         ST_NODE_MUL: begin
            mul_x = ires_ff; mul_g = g_ff;
            if (sub_ff == 2'd1) begin
               nv_we = 1'b1; nv_wa = ncnt_ff[NW-1:0];
               nv_wd = sat32(36'(vnode_ff) + 36'(mul_y));
               sub_in = 2'd0; state_in = ST_NODE_OUT;
            end else sub_in = 2'd1;
         end
         ST_NODE_OUT: begin
            if (!rv_ff || !rsp_stall) begin
               if (ncnt_ff + 1'b1 == nlim) begin
                  ncnt_in = '0; state_in = ST_IDLE;
               end else begin
                  ncnt_in = ncnt_ff + 1'b1; state_in = ST_NODE_RD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; ncnt_ff <= '0; ccnt_ff <= '0; sub_ff <= '0;
         act_comp_ff <= 4'd0; act_node_ff <= 4'd8;
         hvalid_ff <= '0; gvalid_ff <= '0; vvalid_ff <= '0; cvalid_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in; ncnt_ff <= ncnt_in; ccnt_ff <= ccnt_in; sub_ff <= sub_in;
         if (csr_write && csr_index == CSR_ACTIVE_COMPONENTS) act_comp_ff <= csr_data;
         if (csr_write && csr_index == CSR_ACTIVE_NODES) act_node_ff <= csr_data;
         if (nh_we) hvalid_ff[nh_wa] <= 1'b1;
         if (ng_we) gvalid_ff[ng_wa] <= 1'b1;
         if (nv_we) vvalid_ff[nv_wa] <= 1'b1;
         if (cv_we) cvalid_ff[cv_wa] <= 1'b1;
         rv_ff <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_FORCE: begin
            for (int i = 0; i < NODE_COUNT; i++) inet_ff[i] <= 36'sd0;
         end
         ST_COMP_RD: begin
            if (sub_ff == 2'd1) begin
               ta_ff <= cp_rd[66:64]; tb_ff <= cp_rd[69:67];
               g_ff <= cp_rd[63:32]; cf_ff <= cp_rd[31:0]; vcap_ff <= cvr;
            end
            if (sub_ff == 2'd2) va_ff <= vnr;
         end
         ST_COMP_MUL: if (sub_ff == 2'd1) cur_ff <= mul_y;
         ST_COMP_CAP: begin
            if (sub_ff == 2'd0) begin
               if (32'(ta_ff) < NODE_COUNT)
                  inet_ff[NW'(ta_ff)] <= inet_ff[NW'(ta_ff)] + 36'(half);
            end else begin
               if (32'(tb_ff) < NODE_COUNT)
                  inet_ff[NW'(tb_ff)] <= inet_ff[NW'(tb_ff)] - 36'(half);
            end
         end
         ST_NODE_RD: if (sub_ff == 2'd1) begin
            vnode_ff <= $signed(vnr); ires_ff <= sat32(inet_sel); g_ff <= ngr;
         end
         ST_NODE_MUL: if (sub_ff == 2'd1) vnode_ff <= sat32(36'(vnode_ff) + 36'(mul_y));
         ST_NODE_OUT: if (!rv_ff || !rsp_stall) begin
            rn_ff <= 3'(ncnt_ff); rvolt_ff <= vnode_ff; rcur_ff <= ires_ff;
            rl_ff <= (ncnt_ff + 1'b1 == nlim);
         end
         default: ;
      endcase
   end
endmodule
